// ----- design/multichannel_discrete_differentiator_assert.svh -----
// ----------------------------------------------------------------------------
// multichannel_discrete_differentiator_assert.svh
// assertion macros shared by the differentiator checker
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_DISCRETE_DIFFERENTIATOR_ASSERT_SVH
`define MULTICHANNEL_DISCRETE_DIFFERENTIATOR_ASSERT_SVH

// property checked outside reset
`define MDD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property that also covers the reset cycles
`define MDD_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- design/mdd_pkg.sv -----
// ----------------------------------------------------------------------------
// mdd_pkg
// types, codes and constants of the multichannel discrete differentiator
// ----------------------------------------------------------------------------
`default_nettype none

package mdd_pkg;

    localparam int CHANNELS_DEF  = 16;
    localparam int CH_FIELD_W    = 4;
    localparam int DATA_W        = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int GAIN_W        = 24;
    localparam int ACT_W         = 5;
    localparam int QUEUE_DEPTH   = 2;
    // queue entries plus the item in the back end plus the output register
    localparam int MAX_IN_FLIGHT = QUEUE_DEPTH + 2;

    // arithmetic widths
    localparam int DIFF_W    = 33;                 // |x - x_prev|
    localparam int PROD_W    = DIFF_W + GAIN_W;    // |diff| * alpha
    localparam int NUM_W     = 58;                 // dividend, even for radix 4
    localparam int DIV_STEPS = NUM_W / 2;
    localparam int DEN_W     = 34;                 // h or 3h
    localparam int TERM_W    = 40;                 // |beta * d_prev|
    localparam int SUM_W     = 60;

    localparam logic [GAIN_W-1:0] ALPHA_TWO   = 24'd131072;
    localparam logic [GAIN_W-1:0] ALPHA_ONE   = 24'd65536;
    localparam logic [DATA_W-1:0] BETA_ONE    = 32'd1;
    localparam logic [DATA_W-1:0] RECIP_THREE = 32'hAAAA_AAAB;  // ceil(2^33 / 3)
    localparam int                RECIP_SHIFT = 33;
    localparam int                GAIN_FRAC   = 16;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_STEP = 2'd1,
        ST_BAD_CH  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        METH_X2MV   = 2'd0,
        METH_X2PVD3 = 2'd1,
        METH_PROG   = 2'd2,
        METH_EULER  = 2'd3
    } method_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_METHOD = 3'd0,
        CFG_ALPHA  = 3'd1,
        CFG_BETA   = 3'd2,
        CFG_ACTIVE = 3'd3,
        CFG_START  = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_MUL,
        BK_DIV,
        BK_SUM,
        BK_OUT
    } back_state_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [CH_FIELD_W-1:0] channel;
        logic [DATA_W-1:0]     sample;
        logic [DATA_W-1:0]     step;
        status_t               status;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        method_t           method;
        logic [GAIN_W-1:0] alpha;
        logic [GAIN_W-1:0] beta;
    } gains_t;

    typedef struct packed {
        logic [DATA_W-1:0] echo;
        logic [DATA_W-1:0] deriv;
        status_t           status;
    } result_t;

endpackage

`default_nettype wire

// ----- design/mdd_front.sv -----
// ----------------------------------------------------------------------------
// mdd_front
// accepts sample beats, computes the step size and classifies each item
// ----------------------------------------------------------------------------
`default_nettype none

module mdd_front import mdd_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CH_FIELD_W-1:0] in_channel,
    input  logic [DATA_W-1:0]     in_sample,
    input  logic [DATA_W-1:0]     in_now,
    input  logic                  in_eos,
    input  logic [ACT_W-1:0]      active,
    input  logic                  time_load,
    input  logic [DATA_W-1:0]     time_value,
    input  queue_stat_t           q_stat,
    output logic                  push,
    output item_t                 push_item
);

    localparam logic [8:0] CHANNELS_V = 9'(CHANNELS);

    logic [DATA_W-1:0] step_time_reg;
    logic              bad_ch;
    logic              no_step;

    assign in_ready = !q_stat.full;
    assign push     = in_valid && in_ready;

    assign bad_ch  = ({5'b0, in_channel} >= CHANNELS_V) || ({1'b0, in_channel} >= active);
    assign no_step = (in_now <= step_time_reg);

    always_comb begin
        push_item.channel = in_channel;
        push_item.sample  = in_sample;
        push_item.step    = in_now - step_time_reg;
        if (bad_ch) begin
            push_item.status = ST_BAD_CH;
        end else if (no_step) begin
            push_item.status = ST_NO_STEP;
        end else begin
            push_item.status = ST_OK;
        end
    end

    // start write or end-of-step mark moves step time, whatever the class
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_time_reg <= '0;
        end else if (time_load) begin
            step_time_reg <= time_value;
        end else if (push && in_eos) begin
            step_time_reg <= in_now;
        end
    end

endmodule

`default_nettype wire

// ----- design/mdd_queue.sv -----
// ----------------------------------------------------------------------------
// mdd_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module mdd_queue import mdd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  item_t       push_item,
    input  logic        pop,
    output item_t       pop_item,
    output queue_stat_t q_stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign q_stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_item     = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/mdd_back.sv -----
// ----------------------------------------------------------------------------
// mdd_back
// per-channel history memory, gain multipliers and radix-4 divider
// ----------------------------------------------------------------------------
`default_nettype none

module mdd_back import mdd_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  gains_t      gains,
    input  queue_stat_t q_stat,
    input  item_t       pop_item,
    output logic        pop,
    output logic        res_valid,
    input  logic        res_ready,
    output result_t     res
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(DIV_STEPS);

    back_state_t state_reg, state_next;

    // history memory: sample in the upper half, derivative in the lower half
    logic [2*DATA_W-1:0] hist_mem [CHANNELS];
    logic [CHANNELS-1:0] valid_reg;
    logic [2*DATA_W-1:0] hist_reg;
    logic                hvalid_reg;
    logic                mem_we;
    logic [CH_W-1:0]     rd_addr;
    logic [CH_W-1:0]     wr_addr;

    item_t               item_reg;
    logic [DIFF_W-1:0]   diff_mag_reg;
    logic                diff_neg_reg;
    logic [DATA_W-1:0]   dp_mag_reg;
    logic                dp_neg_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [NUM_W-1:0]    quo_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [TERM_W-1:0]   term_reg;
    logic [CNT_W-1:0]    cnt_reg;
    result_t             res_reg;

    // read-stage values
    logic [DATA_W-1:0]   prev_x;
    logic [DATA_W-1:0]   prev_d;
    logic [DIFF_W-1:0]   diff;
    logic [DEN_W-1:0]    den;

    // multiply-stage values
    logic [GAIN_W-1:0]   alpha_sel;
    logic [PROD_W-1:0]   prod_a;
    logic [DATA_W-1:0]   beta_sel;
    logic [2*DATA_W-1:0] prod_b;
    logic [TERM_W-1:0]   term;

    // divider step values
    logic [DEN_W:0]      r1;
    logic                ge1;
    logic [DEN_W-1:0]    r1s;
    logic [DEN_W:0]      r2;
    logic                ge2;
    logic [DEN_W-1:0]    r2s;

    // final sum
    logic [SUM_W-1:0]    q_s;
    logic [SUM_W-1:0]    t_s;
    logic [SUM_W-1:0]    d_sum;
    logic [DATA_W-1:0]   d_sat;
    logic                ovf;

    assign rd_addr = CH_W'(pop_item.channel);
    assign wr_addr = CH_W'(item_reg.channel);
    assign res     = res_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty) begin
                    state_next = BK_READ;
                end
            end
            BK_READ: begin
                state_next = (item_reg.status == ST_OK) ? BK_MUL : BK_OUT;
            end
            BK_MUL: begin
                state_next = BK_DIV;
            end
            BK_DIV: begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = BK_SUM;
                end
            end
            BK_SUM: begin
                state_next = BK_OUT;
            end
            BK_OUT: begin
                if (res_ready) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        pop       = 1'b0;
        res_valid = 1'b0;
        mem_we    = 1'b0;
        unique case (state_reg)
            BK_IDLE: pop       = !q_stat.empty;
            BK_SUM:  mem_we    = 1'b1;
            BK_OUT:  res_valid = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (mem_we) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[wr_addr] <= {item_reg.sample, d_sat};
        end
        if (pop) begin
            hist_reg   <= hist_mem[rd_addr];
            hvalid_reg <= valid_reg[rd_addr];
        end
    end

    // read stage: history, differences, divisor
    always_comb begin
        prev_x = hvalid_reg ? hist_reg[2*DATA_W-1:DATA_W] : '0;
        prev_d = hvalid_reg ? hist_reg[DATA_W-1:0] : '0;
        diff   = {item_reg.sample[DATA_W-1], item_reg.sample} - {prev_x[DATA_W-1], prev_x};
        if (gains.method == METH_X2PVD3) begin
            den = DEN_W'(item_reg.step) + {1'b0, item_reg.step, 1'b0};
        end else begin
            den = DEN_W'(item_reg.step);
        end
    end

    // multiply stage: alpha on the difference, beta on the old derivative
    always_comb begin
        case (gains.method)
            METH_X2MV:   alpha_sel = ALPHA_TWO;
            METH_X2PVD3: alpha_sel = ALPHA_TWO;
            METH_PROG:   alpha_sel = gains.alpha;
            default:     alpha_sel = ALPHA_ONE;
        endcase
        case (gains.method)
            METH_X2MV:   beta_sel = BETA_ONE;
            METH_X2PVD3: beta_sel = RECIP_THREE;
            METH_PROG:   beta_sel = DATA_W'(gains.beta);
            default:     beta_sel = '0;
        endcase
        prod_a = PROD_W'(diff_mag_reg) * PROD_W'(alpha_sel);
        prod_b = (2*DATA_W)'(dp_mag_reg) * (2*DATA_W)'(beta_sel);
        case (gains.method)
            METH_X2PVD3: term = TERM_W'(prod_b >> RECIP_SHIFT);
            METH_PROG:   term = TERM_W'(prod_b >> GAIN_FRAC);
            default:     term = TERM_W'(prod_b);
        endcase
    end

    // two restoring steps per cycle
    always_comb begin
        r1  = {rem_reg, quo_reg[NUM_W-1]};
        ge1 = (r1 >= {1'b0, den_reg});
        r1s = ge1 ? DEN_W'(r1 - {1'b0, den_reg}) : DEN_W'(r1);
        r2  = {r1s, quo_reg[NUM_W-2]};
        ge2 = (r2 >= {1'b0, den_reg});
        r2s = ge2 ? DEN_W'(r2 - {1'b0, den_reg}) : DEN_W'(r2);
    end

    // signed combination and saturation to q16.16
    always_comb begin
        q_s   = diff_neg_reg ? -SUM_W'(quo_reg) : SUM_W'(quo_reg);
        t_s   = dp_neg_reg ? SUM_W'(term_reg) : -SUM_W'(term_reg);
        d_sum = q_s + t_s;
        ovf   = (d_sum[SUM_W-1:DATA_W-1] != {(SUM_W - DATA_W + 1){d_sum[SUM_W-1]}});
        if (!ovf) begin
            d_sat = d_sum[DATA_W-1:0];
        end else if (d_sum[SUM_W-1]) begin
            d_sat = {1'b1, {(DATA_W - 1){1'b0}}};
        end else begin
            d_sat = {1'b0, {(DATA_W - 1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            BK_IDLE: begin
                item_reg <= pop_item;
            end
            BK_READ: begin
                diff_neg_reg <= diff[DIFF_W-1];
                diff_mag_reg <= diff[DIFF_W-1] ? -diff : diff;
                dp_neg_reg   <= prev_d[DATA_W-1];
                dp_mag_reg   <= prev_d[DATA_W-1] ? -prev_d : prev_d;
                den_reg      <= den;
                if (item_reg.status == ST_NO_STEP) begin
                    res_reg <= '{echo: prev_x, deriv: prev_d, status: ST_NO_STEP};
                end else begin
                    res_reg <= '{echo: '0, deriv: '0, status: ST_BAD_CH};
                end
            end
            BK_MUL: begin
                quo_reg  <= NUM_W'(prod_a);
                term_reg <= term;
                rem_reg  <= '0;
                cnt_reg  <= '0;
            end
            BK_DIV: begin
                quo_reg <= {quo_reg[NUM_W-3:0], ge1, ge2};
                rem_reg <= r2s;
                cnt_reg <= cnt_reg + 1'b1;
            end
            BK_SUM: begin
                res_reg <= '{echo: item_reg.sample, deriv: d_sat, status: ST_OK};
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/multichannel_discrete_differentiator.sv -----
// ----------------------------------------------------------------------------
// multichannel_discrete_differentiator
// recursive discrete-time differentiator over up to CHANNELS channels
// ----------------------------------------------------------------------------
// Each input beat carries one sample for one channel together with the
// current time; the block returns one result beat per input beat, in order.
// The front end computes the step h = now - stored step time, classifies the
// beat (bad channel, non-positive step, normal) and commits now as the stored
// step time when tlast is set. A two-entry queue separates it from the back
// end, which reads the channel history, forms |x - x_prev| * alpha and
// |d_prev| * beta, divides by h (or 3h) in a radix-4 restoring divider and
// saturates the result to q16.16. A normal beat passes the read, multiply,
// divide and sum states; bad-channel and no-step beats go from read straight
// to output. The front keeps accepting while the queue has room, so up to
// four beats can be in flight. Channel history is held in a memory with one
// valid flag per channel, cleared by reset, so no clearing pass is needed.
// Configuration may only be written while no beat is in flight.
`default_nettype none

module multichannel_discrete_differentiator import mdd_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // sample input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*DATA_W-1:0]   s_tdata,   // [31:0] sample_value, [63:32] now_time
    input  logic [CH_FIELD_W-1:0] s_tuser,   // [3:0] channel
    input  logic                  s_tlast,   // end_of_step
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*DATA_W-1:0]   m_tdata,   // [31:0] echo_value, [63:32] derivative
    output logic [1:0]            m_tuser,   // [1:0] status
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    method_t           method_reg;
    logic [GAIN_W-1:0] alpha_reg;
    logic [GAIN_W-1:0] beta_reg;
    logic [ACT_W-1:0]  active_reg;
    logic              time_load;
    gains_t            gains;

    // front to back
    logic              push;
    item_t             push_item;
    logic              pop;
    item_t             pop_item;
    queue_stat_t       q_stat;

    // back to output register
    logic              res_valid;
    logic              res_ready;
    result_t           res;

    // output register
    logic                m_tvalid_reg;
    logic [2*DATA_W-1:0] m_tdata_reg;
    logic [1:0]          m_tuser_reg;

    assign time_load = cfg_we && (cfg_index == CFG_START);
    assign gains     = '{method: method_reg, alpha: alpha_reg, beta: beta_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_reg <= METH_EULER;
            alpha_reg  <= '0;
            beta_reg   <= '0;
            active_reg <= ACT_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_METHOD: method_reg <= method_t'(cfg_data[1:0]);
                CFG_ALPHA:  alpha_reg  <= cfg_data[GAIN_W-1:0];
                CFG_BETA:   beta_reg   <= cfg_data[GAIN_W-1:0];
                CFG_ACTIVE: active_reg <= cfg_data[ACT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mdd_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_channel (s_tuser),
        .in_sample  (s_tdata[DATA_W-1:0]),
        .in_now     (s_tdata[2*DATA_W-1:DATA_W]),
        .in_eos     (s_tlast),
        .active     (active_reg),
        .time_load  (time_load),
        .time_value (cfg_data[DATA_W-1:0]),
        .q_stat     (q_stat),
        .push       (push),
        .push_item  (push_item)
    );

    mdd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_stat    (q_stat)
    );

    mdd_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .gains     (gains),
        .q_stat    (q_stat),
        .pop_item  (pop_item),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register, loads whenever it is empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_tdata_reg <= {res.deriv, res.echo};
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ----- design/mdd_checker.sv -----
// ----------------------------------------------------------------------------
// mdd_checker
// port-level checks on the differentiator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "multichannel_discrete_differentiator_assert.svh"

module mdd_checker import mdd_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [2*DATA_W-1:0] m_tdata,
    input logic [1:0]          m_tuser
);

    localparam int PEND_W = $clog2(MAX_IN_FLIGHT + 2);

    logic              in_beat;
    logic              out_beat;
    logic [PEND_W-1:0] pend_reg;
    logic [PEND_W-1:0] pend_next;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    always_comb begin
        pend_next = pend_reg;
        if (in_beat && !out_beat) begin
            pend_next = pend_reg + 1'b1;
        end else if (out_beat && !in_beat) begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // no result without an earlier sample beat
    `MDD_ASSERT(a_no_phantom, out_beat |-> (pend_reg != '0), "result beat with nothing in flight")

    // backpressure keeps the in-flight count within queue and stages
    `MDD_ASSERT(a_bounded, pend_reg <= PEND_W'(MAX_IN_FLIGHT), "too many beats in flight")

    // a bad channel returns zero data
    `MDD_ASSERT(a_bad_zero, (m_tvalid && (m_tuser == ST_BAD_CH)) |-> (m_tdata == '0), "bad channel with data")

    // stalled result holds
    `MDD_ASSERT(a_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "result changed under stall")

    // output idle after reset
    `MDD_ASSERT_RST(a_reset_idle, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind multichannel_discrete_differentiator mdd_checker u_mdd_checker (.*);

`default_nettype wire
